// ----- hdl/ptt_pkg.sv -----
// ptt_pkg: shared types and constants for the pending tag tracker.
// Used by ptt_match and pending_tag_tracker_ttl; depends on nothing.
`timescale 1ns / 1ps

package ptt_pkg;

  localparam int TAG_W       = 8;
  localparam int TIME_W      = 48;
  localparam int HANDLE_W    = 64;
  localparam int TTL_W       = 32;
  localparam int REQ_W       = 2;
  localparam int NUM_SLOTS_DEF = 4;

  localparam logic [TTL_W-1:0]  TTL_RESET = TTL_W'(60000);
  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

  typedef enum logic [REQ_W-1:0] {
    REQ_TRACK = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_TAKE  = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  // Summary flags from the slot lookup.
  typedef struct packed {
    logic hit;       // a live slot holds the tag
    logic has_free;  // some slot is not live
  } match_flags_t;

endpackage

// ----- hdl/pending_tag_tracker_ttl.sv -----
// Pending tag tracker with time-to-live: top level.
// Result path: the input register, then the result register.
// Throughput: one transaction per cycle while out_stall is low; the lookup against
// all slots is combinational between the input register and the result register.
// Reset (rst_n, synchronous): table empty, time 0, ttl_ticks 60000, both
// channels empty. Depends on ptt_pkg and ptt_match.
`timescale 1ns / 1ps

module pending_tag_tracker_ttl #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration: ttl_ticks
  input  logic                          cfg_wr_en,
  input  logic [ptt_pkg::TTL_W-1:0]     cfg_wr_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ptt_pkg::REQ_W-1:0]     in_req_type,
  input  logic [ptt_pkg::TAG_W-1:0]     in_seq_tag,
  input  logic [ptt_pkg::HANDLE_W-1:0]  in_command_handle,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [ptt_pkg::HANDLE_W-1:0]  out_handle_out,
  output logic                          out_refreshed,
  output logic                          out_evicted,
  output logic [ptt_pkg::TAG_W-1:0]     out_evicted_tag
);

  localparam int TIME_W   = ptt_pkg::TIME_W;
  localparam int TAG_W    = ptt_pkg::TAG_W;
  localparam int HANDLE_W = ptt_pkg::HANDLE_W;
  localparam int TTL_W    = ptt_pkg::TTL_W;

  // ---------------------------------------------------------------
  // State
  // ---------------------------------------------------------------
  logic [TTL_W-1:0]                    ttl_r;
  logic [TIME_W-1:0]                   time_r, time_nxt;
  logic [NUM_SLOTS-1:0]                valid_r, valid_nxt;
  // slot payload, meaningful only where valid
  logic [NUM_SLOTS-1:0][TAG_W-1:0]     tag_r;
  logic [NUM_SLOTS-1:0][TIME_W-1:0]    expiry_r;
  logic [NUM_SLOTS-1:0][HANDLE_W-1:0]  handle_r;
  logic [NUM_SLOTS-1:0]                wr_oh;

  // input register
  logic                                in_valid_r;
  ptt_pkg::req_t                       req_r;
  logic [TAG_W-1:0]                    seq_tag_r;
  logic [HANDLE_W-1:0]                 cmd_handle_r;

  // result register
  logic                                out_valid_r;
  logic                                found_r, found_nxt;
  logic [HANDLE_W-1:0]                 hout_r, hout_nxt;
  logic                                refr_r, refr_nxt;
  logic                                evic_r, evic_nxt;
  logic [TAG_W-1:0]                    etag_r, etag_nxt;

  // ---------------------------------------------------------------
  // Handshake: the result register frees up when it is empty or being
  // taken; the input register moves into it whenever it is free.
  // ---------------------------------------------------------------
  logic out_free;
  logic advance;
  logic in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // ---------------------------------------------------------------
  // Slot lookup
  // ---------------------------------------------------------------
  logic [NUM_SLOTS-1:0]   live, hit_oh, free_oh, evict_oh, scan_mask;
  ptt_pkg::match_flags_t  flags;

  ptt_match #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_match (
    .slot_valid  (valid_r),
    .slot_tag    (tag_r),
    .slot_expiry (expiry_r),
    .cur_time    (time_r),
    .tag         (seq_tag_r),
    .live        (live),
    .hit_oh      (hit_oh),
    .free_oh     (free_oh),
    .evict_oh    (evict_oh),
    .scan_mask   (scan_mask),
    .flags       (flags)
  );

  // New expiry: now + ttl, clamped at the top of the time range.
  logic [TIME_W:0]     exp_sum;
  logic [TIME_W-1:0]   exp_now;

  assign exp_sum = {1'b0, time_r} + (TIME_W + 1)'(ttl_r);
  assign exp_now = exp_sum[TIME_W] ? ptt_pkg::TIME_MAX : exp_sum[TIME_W-1:0];

  // ---------------------------------------------------------------
  // Request execution
  // ---------------------------------------------------------------
  always_comb begin
    logic [NUM_SLOTS-1:0] target_oh;
    logic [HANDLE_W-1:0]  hit_handle;
    logic [TAG_W-1:0]     victim_tag;
    target_oh  = flags.has_free ? free_oh : evict_oh;
    hit_handle = '0;
    victim_tag = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit_handle = hit_handle | (hit_oh[i] ? handle_r[i] : '0);
      victim_tag = victim_tag | (evict_oh[i] ? tag_r[i] : '0);
    end

    time_nxt  = time_r;
    valid_nxt = valid_r;
    wr_oh     = '0;
    found_nxt = 1'b0;
    hout_nxt  = '0;
    refr_nxt  = 1'b0;
    evic_nxt  = 1'b0;
    etag_nxt  = '0;

    if (advance) begin
      case (req_r)
        ptt_pkg::REQ_TRACK: begin
          // expired slots seen by the scan are dropped
          for (int i = 0; i < NUM_SLOTS; i++) begin
            valid_nxt[i] = scan_mask[i] ? live[i] : valid_r[i];
          end
          if (flags.hit) begin
            wr_oh    = hit_oh;
            refr_nxt = 1'b1;
          end else begin
            wr_oh     = target_oh;
            valid_nxt = valid_nxt | target_oh;
            if (!flags.has_free) begin
              evic_nxt = 1'b1;
              etag_nxt = victim_tag;
            end
          end
        end
        ptt_pkg::REQ_QUERY: begin
          found_nxt = flags.hit;
        end
        ptt_pkg::REQ_TAKE: begin
          found_nxt = flags.hit;
          hout_nxt  = hit_handle;
          valid_nxt = valid_r & ~hit_oh;
        end
        ptt_pkg::REQ_TICK: begin
          if (time_r != ptt_pkg::TIME_MAX) begin
            time_nxt = time_r + TIME_W'(1);
          end
        end
        default: begin
          time_nxt = time_r;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r       <= ptt_pkg::TTL_RESET;
      time_r      <= '0;
      valid_r     <= '0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ttl_r <= cfg_wr_data;
      end
      time_r  <= time_nxt;
      valid_r <= valid_nxt;
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r        <= ptt_pkg::req_t'(in_req_type);
      seq_tag_r    <= in_seq_tag;
      cmd_handle_r <= in_command_handle;
    end
    if (advance) begin
      found_r <= found_nxt;
      hout_r  <= hout_nxt;
      refr_r  <= refr_nxt;
      evic_r  <= evic_nxt;
      etag_r  <= etag_nxt;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (wr_oh[i]) begin
        tag_r[i]    <= seq_tag_r;
        expiry_r[i] <= exp_now;
        handle_r[i] <= cmd_handle_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_handle_out  = hout_r;
  assign out_refreshed   = refr_r;
  assign out_evicted     = evic_r;
  assign out_evicted_tag = etag_r;

endmodule

// ----- hdl/ptt_match.sv -----
// ptt_match: parallel slot lookup for the pending tag tracker.
// Liveness, first live tag match, first free slot, earliest-expiry slot.
// Depends on ptt_pkg.
`timescale 1ns / 1ps

module ptt_match #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF
) (
  input  logic [NUM_SLOTS-1:0]                       slot_valid,
  input  logic [NUM_SLOTS-1:0][ptt_pkg::TAG_W-1:0]   slot_tag,
  input  logic [NUM_SLOTS-1:0][ptt_pkg::TIME_W-1:0]  slot_expiry,
  input  logic [ptt_pkg::TIME_W-1:0]                 cur_time,
  input  logic [ptt_pkg::TAG_W-1:0]                  tag,
  output logic [NUM_SLOTS-1:0]                       live,
  output logic [NUM_SLOTS-1:0]                       hit_oh,
  output logic [NUM_SLOTS-1:0]                       free_oh,
  output logic [NUM_SLOTS-1:0]                       evict_oh,
  output logic [NUM_SLOTS-1:0]                       scan_mask,
  output ptt_pkg::match_flags_t                      flags
);

  logic [NUM_SLOTS-1:0] tag_hit;

  always_comb begin
    logic seen_hit;
    logic seen_free;
    logic later_hit;
    logic is_min;
    seen_hit  = 1'b0;
    seen_free = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      live[i]    = slot_valid[i] && (slot_expiry[i] >= cur_time);
      tag_hit[i] = live[i] && (slot_tag[i] == tag);
    end
    // first-in-order selection, prefix ORs are independent per slot
    for (int i = 0; i < NUM_SLOTS; i++) begin
      seen_hit  = 1'b0;
      seen_free = 1'b0;
      for (int j = 0; j < i; j++) begin
        seen_hit  = seen_hit | tag_hit[j];
        seen_free = seen_free | !live[j];
      end
      hit_oh[i]  = tag_hit[i] && !seen_hit;
      free_oh[i] = !live[i] && !seen_free;
    end
    // earliest expiry, lowest index wins a tie: all-pairs compare
    for (int i = 0; i < NUM_SLOTS; i++) begin
      is_min = 1'b1;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (j < i && !(slot_expiry[i] < slot_expiry[j])) is_min = 1'b0;
        if (j > i && !(slot_expiry[i] <= slot_expiry[j])) is_min = 1'b0;
      end
      evict_oh[i] = is_min;
    end
    flags.hit      = |tag_hit;
    flags.has_free = !(&live);
    // track scan frees expired slots up to, not including, the hit slot
    for (int i = 0; i < NUM_SLOTS; i++) begin
      later_hit = 1'b0;
      for (int j = i + 1; j < NUM_SLOTS; j++) begin
        later_hit = later_hit | hit_oh[j];
      end
      scan_mask[i] = !flags.hit || later_hit;
    end
  end

endmodule
